FILE: rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// Toy language tokenizer package
// Token kind codes, scanner mode codes, keyword spellings and character
// class helpers shared by the tokenizer.
// ----------------------------------------------------------------------------
package tlt_pkg;

   localparam int KEYWORD_CHARS_DEF = 5;
   localparam int LENGTH_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;

   localparam int KIND_W       = 5;
   localparam int NUM_KEYWORDS = 8;
   localparam int KW_TEXT_W    = 40;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [1:0]        mode_type;

   // Token kinds.
   localparam kind_type KIND_ASSIGN   = 5'd0;
   localparam kind_type KIND_SEMI     = 5'd1;
   localparam kind_type KIND_PLUS     = 5'd2;
   localparam kind_type KIND_MINUS    = 5'd3;
   localparam kind_type KIND_STAR     = 5'd4;
   localparam kind_type KIND_SLASH    = 5'd5;
   localparam kind_type KIND_OROR     = 5'd6;
   localparam kind_type KIND_ANDAND   = 5'd7;
   localparam kind_type KIND_NE       = 5'd8;
   localparam kind_type KIND_NOT      = 5'd9;
   localparam kind_type KIND_LE       = 5'd10;
   localparam kind_type KIND_GE       = 5'd11;
   localparam kind_type KIND_LT       = 5'd12;
   localparam kind_type KIND_GT       = 5'd13;
   localparam kind_type KIND_EQ       = 5'd14;
   localparam kind_type KIND_KEYWORD0 = 5'd15;
   localparam kind_type KIND_IDENT    = 5'd23;
   localparam kind_type KIND_NUMBER   = 5'd24;
   localparam kind_type KIND_END      = 5'd25;
   localparam kind_type KIND_ERROR    = 5'd26;

   // Scanner modes.
   localparam mode_type MODE_IDLE   = 2'd0;
   localparam mode_type MODE_OPER   = 2'd1;
   localparam mode_type MODE_IDENT  = 2'd2;
   localparam mode_type MODE_NUMBER = 2'd3;

   // Keyword spelling, first character in the lowest byte.
   function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [2:0] k);
      logic [KW_TEXT_W-1:0] t;
      unique case (k)
         3'd0:    t = {8'h00, 8'h00, "r", "a", "v"};
         3'd1:    t = {8'h00, "e", "u", "r", "t"};
         3'd2:    t = {"e", "s", "l", "a", "f"};
         3'd3:    t = {8'h00, 8'h00, 8'h00, "f", "i"};
         3'd4:    t = {8'h00, "n", "e", "h", "t"};
         3'd5:    t = {8'h00, "e", "s", "l", "e"};
         3'd6:    t = {"e", "l", "i", "h", "w"};
         default: t = {8'h00, 8'h00, 8'h00, "o", "d"};
      endcase
      return t;
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      logic [2:0] n;
      unique case (k)
         3'd0, 3'd7:       n = 3'd2;
         3'd3:             n = 3'd2;
         3'd2, 3'd6:       n = 3'd5;
         default:          n = 3'd4;
      endcase
      // "var" is the one three-letter keyword.
      if (k == 3'd0) n = 3'd3;
      return n;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
   endfunction

   function automatic logic is_decimal(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

endpackage

FILE: rtl/toy_language_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Toy language tokenizer
// Turns a byte stream of source text into kind/start/length tokens with one
// byte of lookahead for two-character operators and keyword recognition.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)            | tlast
//  req_    | in  | text_byte[7:0]                           | end_of_text
//  rsp_    | out | token_kind, token_start, token_length    | last_of_run
//
//  One byte is taken per cycle; its scanning and the state update happen in
//  the same cycle and its zero, one or two tokens are written into a
//  four-entry result queue, which presents one token per cycle when
//  rsp_tready is high. req_tready is high while the queue has room for two
//  tokens, so the input stalls when tokens outpace the consumer.
//  Synchronous reset returns the scanner to idle at position zero and
//  empties the queue.
module toy_language_tokenizer_top
   import tlt_pkg::*;
#(
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   localparam int TDATA_W = ((KIND_W + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // text_byte[7:0]
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // token_kind, token_start, token_length
   output logic               rsp_tlast
);

   localparam int PREFIX_W = 8 * KEYWORD_CHARS;

   typedef struct packed {
      logic [LENGTH_BITS-1:0]   length;
      logic [POSITION_BITS-1:0] start;
      kind_type                 kind;
   } token_type;

   typedef struct packed {
      logic      last;
      token_type tok;
   } entry_type;

   // Scanner state.
   mode_type                 mode_ff, mode_in;
   logic [7:0]               pend_op_ff, pend_op_in;
   logic [PREFIX_W-1:0]      prefix_ff, prefix_in;
   logic                     kw_possible_ff, kw_possible_in;
   logic [POSITION_BITS-1:0] lex_start_ff, lex_start_in;
   logic [LENGTH_BITS-1:0]   lex_len_ff, lex_len_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // Result queue.
   entry_type  queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic       accept;
   logic       pop;
   logic [7:0] b;
   logic       eot;

   token_type  flush_tok, fresh_tok, pair_tok, end_tok, res_a, res_b;
   logic       flush_vld, fresh_vld, res_a_vld, res_b_vld;
   kind_type   pair_kind, ident_kind, fresh_kind;
   logic       pair_hit, can_extend;
   entry_type  item0, item1;
   logic [1:0] push_n;

   assign b      = req_tdata;
   assign eot    = req_tlast;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   assign req_tready = (count_ff < 3'd3);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = TDATA_W'(queue_ff[rd_ptr_ff].tok);
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

   // Token that closes the open lexeme.
   always_comb begin
      ident_kind = KIND_IDENT;
      if (kw_possible_ff) begin
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if ((lex_len_ff == LENGTH_BITS'(kw_len(3'(k))))
                && (prefix_ff == PREFIX_W'(kw_text(3'(k))))) begin
               ident_kind = KIND_KEYWORD0 + KIND_W'(k);
            end
         end
      end

      flush_tok.start  = lex_start_ff;
      flush_tok.length = lex_len_ff;
      flush_tok.kind   = KIND_ERROR;
      flush_vld        = 1'b1;
      unique case (mode_ff)
         MODE_OPER: begin
            flush_tok.length = LENGTH_BITS'(1);
            case (pend_op_ff)
               "!":     flush_tok.kind = KIND_NOT;
               "<":     flush_tok.kind = KIND_LT;
               ">":     flush_tok.kind = KIND_GT;
               default: flush_tok.kind = KIND_ERROR;
            endcase
         end
         MODE_IDENT:  flush_tok.kind = ident_kind;
         MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
         default:     flush_vld = 1'b0;
      endcase
   end

   // Pair completion for a held operator byte.
   always_comb begin
      pair_hit  = 1'b1;
      pair_kind = KIND_ERROR;
      if ((pend_op_ff == ":") && (b == "="))      pair_kind = KIND_ASSIGN;
      else if ((pend_op_ff == "|") && (b == "|")) pair_kind = KIND_OROR;
      else if ((pend_op_ff == "&") && (b == "&")) pair_kind = KIND_ANDAND;
      else if ((pend_op_ff == "!") && (b == "=")) pair_kind = KIND_NE;
      else if ((pend_op_ff == "<") && (b == "=")) pair_kind = KIND_LE;
      else if ((pend_op_ff == ">") && (b == "=")) pair_kind = KIND_GE;
      else pair_hit = 1'b0;
      pair_tok.kind   = pair_kind;
      pair_tok.start  = lex_start_ff;
      pair_tok.length = LENGTH_BITS'(2);
   end

   // Single-byte token for a byte scanned with no lexeme open.
   always_comb begin
      fresh_vld  = 1'b1;
      fresh_kind = KIND_ERROR;
      case (b)
         ";":     fresh_kind = KIND_SEMI;
         "+":     fresh_kind = KIND_PLUS;
         "-":     fresh_kind = KIND_MINUS;
         "*":     fresh_kind = KIND_STAR;
         "/":     fresh_kind = KIND_SLASH;
         "=":     fresh_kind = KIND_EQ;
         default: begin
            if ((b == " ") || (b == 8'h09) || (b == 8'h0a) || (b == ":") || (b == "|")
                || (b == "&") || (b == "!") || (b == "<") || (b == ">")
                || is_alpha(b) || is_decimal(b)) begin
               fresh_vld = 1'b0;
            end
         end
      endcase
      fresh_tok.kind   = fresh_kind;
      fresh_tok.start  = pos_ff;
      fresh_tok.length = LENGTH_BITS'(1);

      end_tok.kind   = KIND_END;
      end_tok.start  = pos_ff;
      end_tok.length = '0;
   end

   assign can_extend = ((mode_ff == MODE_IDENT) && (is_alpha(b) || is_decimal(b) || (b == "#")))
                     || ((mode_ff == MODE_NUMBER) && (is_decimal(b) || (b == "#")));

   // Next scanner state and the tokens this byte produces.
   always_comb begin
      mode_in        = mode_ff;
      pend_op_in     = pend_op_ff;
      prefix_in      = prefix_ff;
      kw_possible_in = kw_possible_ff;
      lex_start_in   = lex_start_ff;
      lex_len_in     = lex_len_ff;
      pos_in         = pos_ff + POSITION_BITS'(1);
      res_a          = flush_tok;
      res_a_vld      = 1'b0;
      res_b          = fresh_tok;
      res_b_vld      = 1'b0;

      if (eot) begin
         res_a_vld      = flush_vld;
         res_b          = end_tok;
         res_b_vld      = 1'b1;
         mode_in        = MODE_IDLE;
         pend_op_in     = '0;
         prefix_in      = '0;
         kw_possible_in = 1'b1;
         lex_start_in   = '0;
         lex_len_in     = '0;
         pos_in         = '0;
      end else if ((mode_ff == MODE_OPER) && pair_hit) begin
         res_a     = pair_tok;
         res_a_vld = 1'b1;
         mode_in   = MODE_IDLE;
      end else if (can_extend) begin
         if (mode_ff == MODE_IDENT) begin
            if (lex_len_ff < LENGTH_BITS'(KEYWORD_CHARS)) begin
               for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  if (lex_len_ff == LENGTH_BITS'(i)) prefix_in[8*i +: 8] = b;
               end
            end else begin
               kw_possible_in = 1'b0;
            end
         end
         if (lex_len_ff != {LENGTH_BITS{1'b1}}) lex_len_in = lex_len_ff + LENGTH_BITS'(1);
      end else begin
         res_a_vld = flush_vld;
         res_b_vld = fresh_vld;
         mode_in   = MODE_IDLE;
         if ((b == ":") || (b == "|") || (b == "&") || (b == "!") || (b == "<")
             || (b == ">")) begin
            mode_in      = MODE_OPER;
            pend_op_in   = b;
            lex_start_in = pos_ff;
            lex_len_in   = LENGTH_BITS'(1);
         end else if (is_alpha(b)) begin
            mode_in        = MODE_IDENT;
            prefix_in      = PREFIX_W'(b);
            kw_possible_in = 1'b1;
            lex_start_in   = pos_ff;
            lex_len_in     = LENGTH_BITS'(1);
         end else if (is_decimal(b)) begin
            mode_in        = MODE_NUMBER;
            prefix_in      = '0;
            kw_possible_in = 1'b0;
            lex_start_in   = pos_ff;
            lex_len_in     = LENGTH_BITS'(1);
         end
      end
   end

   // Pack the produced tokens to the front and mark the final one.
   always_comb begin
      item0.tok  = res_a_vld ? res_a : res_b;
      item0.last = !(res_a_vld && res_b_vld);
      item1.tok  = res_b;
      item1.last = 1'b1;
      push_n     = 2'(res_a_vld) + 2'(res_b_vld);
      if (!accept) push_n = 2'd0;
      wr_ptr_in  = wr_ptr_ff + push_n;
      rd_ptr_in  = rd_ptr_ff + 2'(pop);
      count_in   = count_ff + 3'(push_n) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         pend_op_ff     <= '0;
         prefix_ff      <= '0;
         kw_possible_ff <= 1'b1;
         lex_start_ff   <= '0;
         lex_len_ff     <= '0;
         pos_ff         <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (accept) begin
            mode_ff        <= mode_in;
            pend_op_ff     <= pend_op_in;
            prefix_ff      <= prefix_in;
            kw_possible_ff <= kw_possible_in;
            lex_start_ff   <= lex_start_in;
            lex_len_ff     <= lex_len_in;
            pos_ff         <= pos_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) queue_ff[wr_ptr_ff] <= item0;
      if (push_n == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= item1;
   end

endmodule

FILE: tb/token_stream_checker.sv
// ----------------------------------------------------------------------------
// Token stream checker
// Watches both channels of the tokenizer. Every accepted source byte is run
// through a behavioural scanner that predicts the tokens it should produce,
// and every accepted token is compared field by field with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module token_stream_checker
   import tlt_pkg::*;
#(
   parameter int RSP_W = ((KIND_W + POSITION_BITS_DEF + LENGTH_BITS_DEF + 7) / 8) * 8
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,   // text_byte[7:0]
   input  logic             req_tlast,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // token_kind, token_start, token_length
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               pending_tokens,
   output int               checked_tokens
);

   typedef struct {
      kind_type    kind;
      logic [31:0] start;
      logic [15:0] length;
      logic        last;
   } expected_token_type;

   string keyword_spellings [NUM_KEYWORDS] =
      '{"var", "true", "false", "if", "then", "else", "while", "do"};

   // Scanner state.
   mode_type    scan_mode;
   logic [7:0]  held_op;
   logic [39:0] kw_prefix;
   logic        kw_possible;
   logic [31:0] lex_start;
   logic [15:0] lex_len;
   logic [31:0] next_pos;

   // Tokens produced by the byte being scanned, at most two.
   kind_type    step_kind  [2];
   logic [31:0] step_start [2];
   logic [15:0] step_len   [2];
   int          step_count;

   expected_token_type awaited_tokens[$];
   int                 failures = 0;
   int                 matched = 0;

   function automatic logic is_word_start(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_numeral(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [39:0] packed_spelling(input string s);
      logic [39:0] w;
      w = '0;
      for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic void clear_scanner();
      scan_mode   = MODE_IDLE;
      held_op     = 8'h00;
      kw_prefix   = '0;
      kw_possible = 1'b1;
      lex_start   = '0;
      lex_len     = '0;
      next_pos    = '0;
   endfunction

   function automatic void add_token(input kind_type k, input logic [31:0] s,
                                     input logic [15:0] l);
      if (step_count < 2) begin
         step_kind[step_count]  = k;
         step_start[step_count] = s;
         step_len[step_count]   = l;
         step_count++;
      end
   endfunction

   // An identifier is a keyword only when its first characters and its
   // length both match; anything longer than the prefix window never is.
   function automatic kind_type word_kind();
      kind_type k;
      k = KIND_IDENT;
      if (kw_possible) begin
         for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (lex_len == 16'(keyword_spellings[i].len()) &&
                kw_prefix == packed_spelling(keyword_spellings[i]))
               k = kind_type'(KIND_KEYWORD0 + i);
         end
      end
      return k;
   endfunction

   function automatic kind_type single_kind(input logic [7:0] op);
      kind_type k;
      case (op)
         "!":     k = KIND_NOT;
         "<":     k = KIND_LT;
         ">":     k = KIND_GT;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic pair_kind_of(input logic [7:0] op, input logic [7:0] b,
                                         output kind_type k);
      k = KIND_ERROR;
      if (op == ":" && b == "=")      k = KIND_ASSIGN;
      else if (op == "|" && b == "|") k = KIND_OROR;
      else if (op == "&" && b == "&") k = KIND_ANDAND;
      else if (op == "!" && b == "=") k = KIND_NE;
      else if (op == "<" && b == "=") k = KIND_LE;
      else if (op == ">" && b == "=") k = KIND_GE;
      return k != KIND_ERROR;
   endfunction

   function automatic void close_lexeme();
      case (scan_mode)
         MODE_OPER:   add_token(single_kind(held_op), lex_start, 16'd1);
         MODE_IDENT:  add_token(word_kind(), lex_start, lex_len);
         MODE_NUMBER: add_token(KIND_NUMBER, lex_start, lex_len);
         default: ;
      endcase
      scan_mode = MODE_IDLE;
   endfunction

   function automatic void open_lexeme(input logic [7:0] b, input logic [31:0] pos);
      scan_mode = MODE_IDLE;
      case (b)
         " ", "\t", "\n": ;
         ";": add_token(KIND_SEMI, pos, 16'd1);
         "+": add_token(KIND_PLUS, pos, 16'd1);
         "-": add_token(KIND_MINUS, pos, 16'd1);
         "*": add_token(KIND_STAR, pos, 16'd1);
         "/": add_token(KIND_SLASH, pos, 16'd1);
         "=": add_token(KIND_EQ, pos, 16'd1);
         ":", "|", "&", "!", "<", ">": begin
            scan_mode = MODE_OPER;
            held_op   = b;
            lex_start = pos;
            lex_len   = 16'd1;
         end
         default: begin
            if (is_word_start(b)) begin
               scan_mode   = MODE_IDENT;
               kw_prefix   = 40'(b);
               kw_possible = 1'b1;
               lex_start   = pos;
               lex_len     = 16'd1;
            end else if (is_numeral(b)) begin
               scan_mode   = MODE_NUMBER;
               kw_prefix   = '0;
               kw_possible = 1'b0;
               lex_start   = pos;
               lex_len     = 16'd1;
            end else begin
               add_token(KIND_ERROR, pos, 16'd1);
            end
         end
      endcase
   endfunction

   function automatic void grow_lexeme(input logic [7:0] b);
      if (scan_mode == MODE_IDENT) begin
         if (lex_len < 16'(KEYWORD_CHARS_DEF)) kw_prefix = kw_prefix | (40'(b) << (8 * lex_len));
         else kw_possible = 1'b0;
      end
      if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic eot);
      expected_token_type t;
      kind_type           k;
      logic [31:0]        pos;
      pos = next_pos;
      step_count = 0;
      if (eot) begin
         close_lexeme();
         add_token(KIND_END, pos, 16'd0);
         clear_scanner();
      end else begin
         if (scan_mode == MODE_OPER) begin
            if (pair_kind_of(held_op, b, k)) begin
               add_token(k, lex_start, 16'd2);
               scan_mode = MODE_IDLE;
            end else begin
               close_lexeme();
               open_lexeme(b, pos);
            end
         end else if (scan_mode == MODE_IDENT
                      && (is_word_start(b) || is_numeral(b) || b == "#")) begin
            grow_lexeme(b);
         end else if (scan_mode == MODE_NUMBER && (is_numeral(b) || b == "#")) begin
            grow_lexeme(b);
         end else begin
            close_lexeme();
            open_lexeme(b, pos);
         end
         next_pos = pos + 32'd1;
      end
      for (int i = 0; i < step_count; i++) begin
         t.kind   = step_kind[i];
         t.start  = step_start[i];
         t.length = step_len[i];
         t.last   = (i == step_count - 1);
         awaited_tokens.push_back(t);
      end
   endfunction

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      failures++;
      $display("%0t: token %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   function automatic void check_token(input logic [RSP_W-1:0] data, input logic last);
      expected_token_type want;
      expected_token_type got;
      got.kind   = data[KIND_W-1:0];
      got.start  = data[KIND_W +: 32];
      got.length = data[KIND_W+32 +: 16];
      got.last   = last;
      if (awaited_tokens.size() == 0) begin
         failures++;
         $display("%0t: unexpected token, expected none, got kind %0d start %0d length %0d",
                  $time, got.kind, got.start, got.length);
      end else begin
         want = awaited_tokens.pop_front();
         matched++;
         if (got.kind !== want.kind)     note_mismatch("kind", 32'(want.kind), 32'(got.kind));
         if (got.start !== want.start)   note_mismatch("start", want.start, got.start);
         if (got.length !== want.length) note_mismatch("length", 32'(want.length),
                                                       32'(got.length));
         if (got.last !== want.last)     note_mismatch("last", 32'(want.last), 32'(got.last));
      end
   endfunction

   // Bytes are scanned before tokens are checked, so a token that leaves in
   // the cycle after its byte is already awaited.
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         awaited_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_token(rsp_tdata, rsp_tlast);
      end
      fail_count     <= failures;
      pending_tokens <= awaited_tokens.size();
      checked_tokens <= matched;
   end

endmodule

FILE: tb/toy_language_tokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// Toy language tokenizer testbench
// Feeds the tokenizer a directed string of operators and awkward bytes, one
// very long identifier, and then random source text built from keywords,
// identifiers, numbers, operators and noise, under three flow-control
// settings. A separate checker predicts and compares every token.
// ----------------------------------------------------------------------------
module toy_language_tokenizer_top_tb;
   import tlt_pkg::*;

   localparam int RSP_W        = ((KIND_W + POSITION_BITS_DEF + LENGTH_BITS_DEF + 7) / 8) * 8;
   localparam int LONG_WORD    = 260;
   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 1_000_000;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;   // text_byte[7:0]
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;            // token_kind, token_start, token_length
   logic             rsp_tlast;

   int fail_count;
   int pending_tokens;
   int checked_tokens;
   int bytes_sent    = 0;
   int texts_ended   = 0;
   int send_idle_pct = 12;
   int recv_idle_pct = 67;

   string keywords [NUM_KEYWORDS] =
      '{"var", "true", "false", "if", "then", "else", "while", "do"};
   string operators [15] =
      '{":=", ";", "+", "-", "*", "/", "||", "&&", "!=", "!", "<=", ">=", "<", ">", "="};
   string pair_starters = ":|&";
   string blanks        = " \t\n";

   toy_language_tokenizer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   token_stream_checker #(.RSP_W(RSP_W)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_tokens (pending_tokens),
      .checked_tokens (checked_tokens)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One transaction on the byte channel, preceded by a random gap. The valid
   // is left high after acceptance so that back-to-back bytes need no gap.
   task automatic send_item(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (eot) texts_ended++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] random_letter();
      if ($urandom_range(1)) return 8'($urandom_range("z", "a"));
      return 8'($urandom_range("Z", "A"));
   endfunction

   // A character that may continue an identifier.
   function automatic logic [7:0] word_char();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return random_letter();
      if (pick < 9) return 8'($urandom_range("9", "0"));
      return "#";
   endfunction

   task automatic send_random_fragment();
      string s;
      case ($urandom_range(19))
         0, 1, 2: send_text(keywords[$urandom_range(NUM_KEYWORDS - 1)]);
         3, 4, 5: begin
            send_item(random_letter(), 1'b0);
            repeat ($urandom_range(8)) send_item(word_char(), 1'b0);
         end
         6, 7: begin
            send_item(8'($urandom_range("9", "0")), 1'b0);
            repeat ($urandom_range(6))
               send_item($urandom_range(4) == 0 ? "#" : 8'($urandom_range("9", "0")), 1'b0);
         end
         8, 9, 10, 11: send_text(operators[$urandom_range(14)]);
         12: begin
            // Words that come close to a keyword without being one.
            s = keywords[$urandom_range(NUM_KEYWORDS - 1)];
            case ($urandom_range(2))
               0: begin
                  send_text(s);
                  send_item(word_char(), 1'b0);
               end
               1:       send_text(s.substr(0, s.len() - 2));
               default: send_text(s.toupper());
            endcase
         end
         13: send_item(pair_starters[$urandom_range(2)], 1'b0);
         14: send_item(8'($urandom_range(255)), 1'b0);
         15: send_item(8'($urandom_range(255)), 1'b1);
         default: send_item(blanks[$urandom_range(2)], 1'b0);
      endcase
      if ($urandom_range(9) < 6) send_item(blanks[$urandom_range(2)], 1'b0);
   endtask

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every operator, adjacent where that tests the lookahead.
      send_text(":=;+-*/||&&!=!<=>=< > =");
      // Lone pair starters, unknown bytes and an end marker that flushes one.
      send_text(":x|");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("&");
      send_item(8'hFF, 1'b1);
      send_text("do 9#;while");
      send_item(8'h00, 1'b1);

      // An identifier far longer than any keyword.
      send_item("w", 1'b0);
      for (int i = 0; i < LONG_WORD; i++) send_item(word_char(), 1'b0);
      send_item(" ", 1'b1);

      goal = bytes_sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         goal = goal + RANDOM_ITEMS / 3;
         while (bytes_sent < goal) send_random_fragment();
      end
      send_item(8'($urandom_range(255)), 1'b1);
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_tokens != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes and end markers over %0d texts; %0d tokens compared.",
               bytes_sent, texts_ended, checked_tokens);
      $display("Covered all operators, lone pair starters, unknown bytes, a long "
               , "identifier and random text under three flow-control settings.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
